// ----- rtl/core/ipv4_dotted_quad_parser_defines.svh -----
// Assertion macros for the dotted-quad parser.
`ifndef IPV4_DOTTED_QUAD_PARSER_DEFINES_SVH
`define IPV4_DOTTED_QUAD_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define IPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("ipq: same-cycle check failed");

// Next-cycle implication, disabled while in reset
`define IPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("ipq: next-cycle check failed");

`endif

// ----- rtl/core/ipq_pkg.sv -----
// Types and constants shared by the dotted-quad parser.
package ipq_pkg;

	// Character codes
	localparam logic [7:0] CH_DOT  = 8'h2e;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	// Part limits
	localparam logic [2:0] MAX_DIGITS    = 3'd3;
	localparam logic [2:0] DIGIT_SAT     = 3'd4;
	localparam logic [2:0] PART_SAT      = 3'd7;
	localparam logic [2:0] PARTS_NEEDED  = 3'd4;
	localparam logic [9:0] OCTET_MAX     = 10'd255;
	localparam logic [9:0] BLOCK_LIMIT   = 10'd256;
	localparam logic [8:0] BLOCK_SIZE_RST = 9'd1;

	// First format fault codes, equal to their status codes
	localparam logic [1:0] FMT_NONE      = 2'd0;
	localparam logic [1:0] FMT_TOO_LONG  = 2'd1;
	localparam logic [1:0] FMT_NON_DIGIT = 2'd2;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_TOO_LONG   = 3'd1,
		ST_NON_DIGIT  = 3'd2,
		ST_PART_COUNT = 3'd3,
		ST_OCTET_BIG  = 3'd4,
		ST_NOT_POW2   = 3'd5,
		ST_OVERFLOW   = 3'd6
	} status_t;

	// Running parse state, also the summary handed on at the last character
	typedef struct packed {
		logic [9:0]  accum;
		logic [2:0]  digits;
		logic [2:0]  parts;
		logic [31:0] addr;
		logic [1:0]  fmt_err;
		logic        too_big;
		logic        bad;
	} parse_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] base_address;
		logic [31:0] end_address;
		logic [8:0]  address_count;
	} result_t;

endpackage

// ----- rtl/core/ipq_intf.sv -----
// Stream and configuration interfaces of the dotted-quad parser.

// Character stream
interface ipq_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       is_last;

	modport source (output valid, output char_code, output is_last, input ready);
	modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

// Result stream
interface ipq_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [31:0] base_address;
	logic [31:0] end_address;
	logic [8:0]  address_count;

	modport source (output valid, output status, output base_address,
		output end_address, output address_count, input ready);
	modport sink   (input valid, input status, input base_address,
		input end_address, input address_count, output ready);
endinterface

// Block size write channel
interface ipq_cfg_if;
	logic       valid;
	logic       ready;
	logic [8:0] block_size;

	modport source (output valid, output block_size, input ready);
	modport sink   (input valid, input block_size, output ready);
endinterface

// ----- rtl/core/ipq_scan.sv -----
// Character scanner: keeps the per-text parse state and closes parts.
module ipq_scan (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  logic [7:0]       char_code,
	input  logic             is_last,
	output ipq_pkg::parse_t  summary
);

	ipq_pkg::parse_t state_q;
	ipq_pkg::parse_t after_char;
	ipq_pkg::parse_t after_close;

	// Finish the current part and shift its octet in
	function automatic ipq_pkg::parse_t close_part(ipq_pkg::parse_t st);
		ipq_pkg::parse_t nx;
		nx = st;
		if (st.fmt_err == ipq_pkg::FMT_NONE) begin
			if (st.digits > ipq_pkg::MAX_DIGITS)
				nx.fmt_err = ipq_pkg::FMT_TOO_LONG;
			else if (st.bad || st.digits == 3'd0)
				nx.fmt_err = ipq_pkg::FMT_NON_DIGIT;
		end
		if (st.accum > ipq_pkg::OCTET_MAX)
			nx.too_big = 1'b1;
		nx.addr = {st.addr[23:0], st.accum[7:0]};
		if (st.parts < ipq_pkg::PART_SAT)
			nx.parts = st.parts + 3'd1;
		nx.accum  = '0;
		nx.digits = '0;
		nx.bad    = 1'b0;
		return nx;
	endfunction

	// One character: a dot closes the part, anything else counts towards it
	function automatic ipq_pkg::parse_t take_char(ipq_pkg::parse_t st, logic [7:0] c);
		ipq_pkg::parse_t nx;
		nx = st;
		if (c == ipq_pkg::CH_DOT) begin
			nx = close_part(st);
		end else begin
			if (c inside {[ipq_pkg::CH_ZERO:ipq_pkg::CH_NINE]}) begin
				// only the first three characters feed the value
				if (st.digits < ipq_pkg::MAX_DIGITS)
					nx.accum = st.accum * 10'd10 + {6'd0, c[3:0]};
			end else begin
				nx.bad = 1'b1;
			end
			if (st.digits < ipq_pkg::DIGIT_SAT)
				nx.digits = st.digits + 3'd1;
		end
		return nx;
	endfunction

	always_comb begin
		after_char  = take_char(state_q, char_code);
		after_close = close_part(after_char);
	end

	assign summary = after_close;

	// State register: cleared after the last character of each text
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (take) begin
			if (is_last)
				state_q <= '0;
			else
				state_q <= after_char;
		end
	end

endmodule

// ----- rtl/core/ipq_verdict.sv -----
// Verdict: status priority and block range from the closed parse summary.
module ipq_verdict (
	input  ipq_pkg::parse_t  summary,
	input  logic [8:0]       block_size,
	output ipq_pkg::result_t result
);

	logic       not_pow2;
	logic [9:0] span_top;
	logic [31:0] last_addr;

	assign not_pow2  = (block_size & (block_size - 9'd1)) != 9'd0;
	assign span_top  = {2'd0, summary.addr[7:0]} + {1'b0, block_size};
	assign last_addr = summary.addr + {23'd0, block_size} - 32'd1;

	always_comb begin
		// Faults in order of precedence
		if (summary.fmt_err != ipq_pkg::FMT_NONE)
			result.status = ipq_pkg::status_t'({1'b0, summary.fmt_err});
		else if (summary.parts != ipq_pkg::PARTS_NEEDED)
			result.status = ipq_pkg::ST_PART_COUNT;
		else if (summary.too_big)
			result.status = ipq_pkg::ST_OCTET_BIG;
		else if (not_pow2)
			result.status = ipq_pkg::ST_NOT_POW2;
		else if (span_top > ipq_pkg::BLOCK_LIMIT)
			result.status = ipq_pkg::ST_OVERFLOW;
		else
			result.status = ipq_pkg::ST_OK;

		if (result.status == ipq_pkg::ST_OK) begin
			result.base_address  = summary.addr;
			result.address_count = block_size;
			result.end_address   = (block_size != 9'd0) ? last_addr : summary.addr;
		end else begin
			result.base_address  = '0;
			result.address_count = '0;
			result.end_address   = '0;
		end
	end

endmodule

// ----- rtl/core/ipv4_dotted_quad_parser.sv -----
// Top level of the dotted-quad parser: input stage, scanner, verdict, result register.
//
//  channel   | dir | fields                                         | transfer
//  char_in   | in  | char_code[7:0], is_last                        | valid & ready
//  res_out   | out | status[2:0], base_address, end_address, count  | valid & ready
//  cfg       | in  | block_size[8:0]                                | valid & ready
//
// One character per cycle sustained while results are taken; a result is presented once its last
// character has passed the input register and then the result register.
// The scan state update and the verdict adder sit between the two registers.
// Reset clears the parse state and both valid flags; block_size returns to 1.
// A stalled result holds the output; the input register still drains into it
// once it is taken, and char_in.ready falls only when both stages are full
// and the waiting result is not being taken.
`include "ipv4_dotted_quad_parser_defines.svh"

module ipv4_dotted_quad_parser (
	input  logic     clk,
	input  logic     arst_n,
	ipq_char_if.sink char_in,
	ipq_res_if.source res_out,
	ipq_cfg_if.sink  cfg
);

	logic             valid_s1;
	logic [7:0]       char_s1;
	logic             last_s1;
	logic             advance;
	logic             take;
	logic [8:0]       block_size_q;
	logic             res_valid_q;
	ipq_pkg::result_t res_q;
	ipq_pkg::parse_t  summary;
	ipq_pkg::result_t verdict;
	logic             res_failed;
	logic             res_good;
	logic             fail_cleared;
	logic             end_same_24;

	// Handshake: the input stage moves on when the result slot is free or draining
	assign advance       = !res_valid_q || res_out.ready;
	assign take          = valid_s1 && advance;
	assign char_in.ready = !valid_s1 || advance;
	assign cfg.ready     = 1'b1;

	// Block size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			block_size_q <= ipq_pkg::BLOCK_SIZE_RST;
		else if (cfg.valid)
			block_size_q <= cfg.block_size;
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (char_in.ready)
			valid_s1 <= char_in.valid;
	end

	always_ff @(posedge clk) begin
		if (char_in.valid && char_in.ready) begin
			char_s1 <= char_in.char_code;
			last_s1 <= char_in.is_last;
		end
	end

	ipq_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.char_code (char_s1),
		.is_last   (last_s1),
		.summary   (summary)
	);

	ipq_verdict u_verdict (
		.summary    (summary),
		.block_size (block_size_q),
		.result     (verdict)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (take && last_s1)
			res_valid_q <= 1'b1;
		else if (res_out.ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (take && last_s1)
			res_q <= verdict;
	end

	assign res_out.valid         = res_valid_q;
	assign res_out.status        = res_q.status;
	assign res_out.base_address  = res_q.base_address;
	assign res_out.end_address   = res_q.end_address;
	assign res_out.address_count = res_q.address_count;

	// Terms for the checks below
	assign res_failed   = res_valid_q && (res_q.status != ipq_pkg::ST_OK);
	assign res_good     = res_valid_q && (res_q.status == ipq_pkg::ST_OK);
	assign fail_cleared = (res_q.base_address == 32'd0) && (res_q.address_count == 9'd0);
	assign end_same_24  = res_q.end_address[31:8] == res_q.base_address[31:8];

	// A failed text reports no address and no count
	`IPQ_ASSERT_NOW(a_fail_zero, clk, arst_n, res_failed, fail_cleared)
	// A good block never leaves the base's /24
	`IPQ_ASSERT_NOW(a_block_in_range, clk, arst_n, res_good, end_same_24)
	// A last character taken from the input stage always yields a result next cycle
	`IPQ_ASSERT_NEXT(a_last_gives_result, clk, arst_n, take && last_s1, res_valid_q)

endmodule

// ----- tb/ipq_parse_checker.sv -----
// Checker for the dotted-quad parser: predicts each result from the transfers seen and compares.
`timescale 1ns / 100ps

module ipq_parse_checker
	import ipq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	ipq_char_if  char_mon,
	ipq_res_if   res_mon,
	ipq_cfg_if   cfg_mon,
	output int   fail_count,
	output int   pending,
	output int   results_seen,
	output logic [6:0] status_seen
);

	// Predicted parse state
	logic [9:0]  acc;
	logic [2:0]  len;
	logic [2:0]  parts;
	logic [31:0] addr;
	logic [1:0]  fmt;
	logic        big;
	logic        bad;
	logic [8:0]  size;

	result_t awaited_results[$];

	function void clear_scan();
		acc = '0;
		len = '0;
		parts = '0;
		addr = '0;
		fmt = FMT_NONE;
		big = 1'b0;
		bad = 1'b0;
	endfunction

	// End of one dot-separated part
	function void close_field();
		if (fmt == FMT_NONE) begin
			if (len > MAX_DIGITS)
				fmt = FMT_TOO_LONG;
			else if (bad || len == 3'd0)
				fmt = FMT_NON_DIGIT;
		end
		if (acc > OCTET_MAX)
			big = 1'b1;
		addr = {addr[23:0], acc[7:0]};
		if (parts < PART_SAT)
			parts = parts + 3'd1;
		acc = '0;
		len = '0;
		bad = 1'b0;
	endfunction

	function void scan_char(input logic [7:0] code);
		if (code == CH_DOT) begin
			close_field();
		end else begin
			// only the first three characters feed the value
			if (code >= CH_ZERO && code <= CH_NINE) begin
				if (len < MAX_DIGITS)
					acc = acc * 10'd10 + {2'b00, code - CH_ZERO};
			end else begin
				bad = 1'b1;
			end
			if (len < DIGIT_SAT)
				len = len + 3'd1;
		end
	endfunction

	// Verdict on the whole text, in the block's error order
	function result_t address_verdict();
		result_t r;
		status_t st;
		close_field();
		if (fmt == FMT_TOO_LONG)
			st = ST_TOO_LONG;
		else if (fmt == FMT_NON_DIGIT)
			st = ST_NON_DIGIT;
		else if (parts != PARTS_NEEDED)
			st = ST_PART_COUNT;
		else if (big)
			st = ST_OCTET_BIG;
		else if ((size & (size - 9'd1)) != 9'd0)
			st = ST_NOT_POW2;
		else if ({2'b00, addr[7:0]} + {1'b0, size} > BLOCK_LIMIT)
			st = ST_OVERFLOW;
		else
			st = ST_OK;
		r = '0;
		r.status = st;
		if (st == ST_OK) begin
			r.base_address = addr;
			r.address_count = size;
			r.end_address = (size != 9'd0) ? addr + {23'd0, size} - 32'd1 : addr;
		end
		clear_scan();
		return r;
	endfunction

	function void check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endfunction

	// Result transfers are compared before new predictions are queued
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			clear_scan();
			size = BLOCK_SIZE_RST;
			awaited_results.delete();
			fail_count = 0;
			results_seen = 0;
			status_seen = '0;
		end else begin
			if (res_mon.valid && res_mon.ready) begin
				results_seen++;
				if (awaited_results.size() == 0) begin
					$error("result transfer with nothing awaited: status %0d", res_mon.status);
					fail_count++;
				end else begin
					want = awaited_results.pop_front();
					status_seen[want.status] = 1'b1;
					check_field("status", {29'd0, want.status}, {29'd0, res_mon.status});
					check_field("base_address", want.base_address, res_mon.base_address);
					check_field("end_address", want.end_address, res_mon.end_address);
					check_field("address_count", {23'd0, want.address_count},
						{23'd0, res_mon.address_count});
				end
			end
			if (cfg_mon.valid && cfg_mon.ready)
				size = cfg_mon.block_size;
			if (char_mon.valid && char_mon.ready) begin
				scan_char(char_mon.char_code);
				if (char_mon.is_last)
					awaited_results = {awaited_results, address_verdict()};
			end
		end
		pending = awaited_results.size();
	end

endmodule

// ----- tb/ipv4_dotted_quad_parser_tb.sv -----
// Testbench top for the dotted-quad parser: clock, reset, stimulus, handshake pacing and verdict.
`timescale 1ns / 100ps

module ipv4_dotted_quad_parser_tb;
	import ipq_pkg::*;

	localparam int CHAR_TARGET = 1400;
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 100;

	logic clk;
	logic arst_n;

	ipq_char_if char_ch ();
	ipq_res_if  res_ch ();
	ipq_cfg_if  cfg_ch ();

	int fail_count;
	int pending;
	int results_seen;
	logic [6:0] status_seen;

	int chars_sent = 0;
	int texts_sent = 0;
	int size_writes = 0;
	int idle_cycles = 0;
	int quiet_left = 0;
	logic [8:0] cur_size = BLOCK_SIZE_RST;
	logic quiet_text = 1'b0;
	logic hold_request = 1'b0;
	logic [7:0] text_q[$];

	ipv4_dotted_quad_parser dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.char_in (char_ch),
		.res_out (res_ch),
		.cfg     (cfg_ch)
	);

	ipq_parse_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_mon     (char_ch),
		.res_mon      (res_ch),
		.cfg_mon      (cfg_ch),
		.fail_count   (fail_count),
		.pending      (pending),
		.results_seen (results_seen),
		.status_seen  (status_seen)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((char_ch.valid && char_ch.ready) || (res_ch.valid && res_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Result side: random stalls, bursts of constant readiness, one long hold-off
	initial begin
		int gap;
		int burst;
		burst = 0;
		res_ch.ready <= 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			if (hold_request) begin
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
			end else begin
				if (burst > 0) begin
					gap = 0;
					burst--;
				end else begin
					gap = $urandom_range(0, 18);
					if ($urandom_range(0, 9) == 0)
						burst = $urandom_range(5, 25);
				end
				if (gap > 0) begin
					res_ch.ready <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
			@(negedge clk);
		end
	end

	// One character transfer, preceded by a random gap except in a quiet text
	task automatic send_char(input logic [7:0] code, input logic last);
		int gap;
		gap = quiet_text ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			char_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		char_ch.valid <= 1'b1;
		char_ch.char_code <= code;
		char_ch.is_last <= last;
		do @(posedge clk); while (!char_ch.ready);
		@(negedge clk);
		chars_sent++;
	endtask

	task automatic send_text();
		for (int i = 0; i < text_q.size(); i++)
			send_char(text_q[i], i == text_q.size() - 1);
		texts_sent++;
	endtask

	// Add one byte at the end of the text being built
	function void append_byte(input logic [7:0] b);
		text_q = {text_q, b};
	endfunction

	task automatic send_str(input string s);
		text_q.delete();
		for (int i = 0; i < s.len(); i++)
			append_byte(s[i]);
		send_text();
	endtask

	// Block size write, only once every result is out and the pipeline has drained
	task automatic set_block_size(input logic [8:0] value);
		char_ch.valid <= 1'b0;
		wait (pending == 0);
		repeat (4) @(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.block_size <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		cur_size = value;
		size_writes++;
	endtask

	// Decimal digits of value, zero padded to width
	function void push_number(input int value, input int width);
		int div;
		div = (width == 3) ? 100 : (width == 2) ? 10 : 1;
		for (int k = 0; k < width; k++) begin
			append_byte(CH_ZERO + 8'((value / div) % 10));
			div = div / 10;
		end
	endfunction

	// Four well-formed parts; the last octet often kept inside the block limit
	function void build_quad();
		int value;
		int width;
		text_q.delete();
		for (int p = 0; p < 4; p++) begin
			if (p == 3 && $urandom_range(0, 1) == 1)
				value = $urandom_range(0, 256 - cur_size);
			else if ($urandom_range(0, 9) == 0)
				value = $urandom_range(256, 999);
			else
				value = $urandom_range(0, 255);
			width = (value > 99) ? 3 : (value > 9) ? 2 : 1;
			if ($urandom_range(0, 5) == 0)
				width = 3;
			if (p > 0)
				append_byte(CH_DOT);
			push_number(value, width);
		end
	endfunction

	// Broken text: wrong part count, long or empty parts, stray bytes
	function void build_rough();
		int n_parts;
		int plen;
		text_q.delete();
		n_parts = $urandom_range(1, 8);
		for (int p = 0; p < n_parts; p++) begin
			if (p > 0)
				append_byte(CH_DOT);
			plen = $urandom_range(0, 5);
			for (int k = 0; k < plen; k++) begin
				case ($urandom_range(0, 9))
					0: append_byte(8'h2d);
					1, 2: append_byte(8'($urandom_range(0, 255)));
					default: append_byte(CH_ZERO + 8'($urandom_range(0, 9)));
				endcase
			end
		end
		if (text_q.size() == 0)
			append_byte(8'($urandom_range(0, 255)));
	endfunction

	initial begin
		int rand_texts;
		arst_n = 1'b0;
		char_ch.valid <= 1'b0;
		char_ch.char_code <= '0;
		char_ch.is_last <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.block_size <= '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// Directed texts under the reset block size of one
		send_str("0.0.0.0");
		send_str("255.255.255.255");
		send_str("1234.5.6.7");
		send_str("12a4.1.1.1");
		send_str("1x.1234.1.1");
		send_str("1..2.3");
		send_str("1.2.3.");
		send_str("-1.2.3.4");
		send_str("1x.2");
		send_str("1.2.3");
		send_str("1.2.3.4.5.6.7.8.9");
		send_str("256.1.1.1");
		send_str("1.999.1.300");
		send_str("9.8.7.\377");
		send_str(".");
		text_q = {8'h00};
		send_text();
		// zero size, largest size, odd size, mid size
		set_block_size(9'd0);
		send_str("10.0.0.255");
		set_block_size(9'd256);
		send_str("10.0.0.0");
		send_str("10.0.0.1");
		set_block_size(9'd3);
		send_str("1.1.1.1");
		send_str("1.1.1");
		send_str("1.1.1.300");
		set_block_size(9'd128);
		send_str("192.168.1.128");
		send_str("192.168.1.129");

		// Random texts, mostly well formed
		rand_texts = 0;
		while (chars_sent < CHAR_TARGET) begin
			if (rand_texts % 12 == 0) begin
				if ($urandom_range(0, 9) < 7)
					set_block_size(($urandom_range(0, 9) == 0) ? 9'd0 : 9'(1 << $urandom_range(0, 8)));
				else
					set_block_size(9'($urandom_range(0, 256)));
			end
			// long result hold-off while characters keep coming back to back
			if (rand_texts == 30) begin
				hold_request = 1'b1;
				quiet_left = 25;
			end
			if (quiet_left > 0) begin
				quiet_text = 1'b1;
				quiet_left--;
			end else begin
				quiet_text = ($urandom_range(0, 3) == 0);
			end
			if ($urandom_range(0, 3) == 0)
				build_rough();
			else
				build_quad();
			send_text();
			rand_texts++;
		end
		char_ch.valid <= 1'b0;

		wait (pending == 0);
		repeat (8) @(posedge clk);
		$display("Run covered %0d address texts (%0d characters) over %0d block size writes.",
			texts_sent, chars_sent, size_writes);
		$display("%0d results compared; status codes seen, one bit per code from 6 down: %b",
			results_seen, status_seen);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ----- ipv4_dotted_quad_parser.f -----
+incdir+rtl/core
rtl/core/ipq_pkg.sv
rtl/core/ipq_intf.sv
rtl/core/ipq_scan.sv
rtl/core/ipq_verdict.sv
rtl/core/ipv4_dotted_quad_parser.sv
tb/ipq_parse_checker.sv
tb/ipv4_dotted_quad_parser_tb.sv
